[src/kvtio_pkg.sv]
package kvtio_pkg;

    // Fixed field widths of the item ports
    localparam int OP_W     = 3;
    localparam int TOKEN_W  = 64;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND_KEY   = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND_VALUE = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND_INDEX = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Input item
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [TOKEN_W-1:0] key_in;
        logic [TOKEN_W-1:0] value_in;
        logic [IDX_W-1:0]   index_in;
    } kvtio_req_t;

    // Result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TOKEN_W-1:0]  key_out;
        logic [TOKEN_W-1:0]  value_out;
        logic [IDX_W-1:0]    index_out;
        logic [COUNT_W-1:0]  count_out;
    } kvtio_res_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the request, clear the scan flags
        logic issue;    // read the next table slot
        logic renum;    // the current scan renumbers the insertion indices
        logic commit;   // apply insert/remove, register the result
    } kvtio_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;   // slot being read is the last one
        logic need_renum;  // remove hit a record
    } kvtio_sts_t;

endpackage

[src/kvtio_ctrl.sv]
module kvtio_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  kvtio_pkg::kvtio_sts_t sts,
    output logic                 busy,
    output logic                 done,
    output kvtio_pkg::kvtio_cmd_t ctl
);
    import kvtio_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_RENUM,
        S_RDRAIN
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                ctl.commit = 1'b1;
                if (sts.need_renum)
                begin
                    state_next = S_RENUM;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RENUM:
            begin
                ctl.issue = 1'b1;
                ctl.renum = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_RDRAIN;
                end
            end
            S_RDRAIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

[src/kvtio_datapath.sv]
module kvtio_datapath #(
    parameter int ENTRIES    = 16,
    parameter int TOKEN_BITS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kvtio_pkg::kvtio_cmd_t ctl,
    input  kvtio_pkg::kvtio_req_t request,
    output kvtio_pkg::kvtio_sts_t sts,
    output kvtio_pkg::kvtio_res_t result
);
    import kvtio_pkg::*;

    localparam int OW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = OW + IDX_W;

    // Captured request
    logic [OP_W-1:0]       op_reg;
    logic [TOKEN_BITS-1:0] key_reg;
    logic [TOKEN_BITS-1:0] val_reg;
    logic [IDX_W-1:0]      idx_reg;

    // Record store
    logic [TOKEN_BITS-1:0] key_mem [ENTRIES];
    logic [TOKEN_BITS-1:0] val_mem [ENTRIES];
    logic [OW-1:0]         ord_mem [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg;
    logic [CW-1:0]         count_reg, count_next;

    // Scan pipeline
    logic [OW-1:0]         rd_addr_reg;
    logic [OW-1:0]         slot_q_reg;
    logic                  live_reg;
    logic                  renum_live_reg;
    logic                  valid_q_reg;
    logic [TOKEN_BITS-1:0] key_q_reg;
    logic [TOKEN_BITS-1:0] val_q_reg;
    logic [OW-1:0]         ord_q_reg;

    // Scan results
    logic                  found_reg;
    logic [OW-1:0]         hit_slot_reg;
    logic [TOKEN_BITS-1:0] hit_key_reg;
    logic [TOKEN_BITS-1:0] hit_val_reg;
    logic [OW-1:0]         hit_ord_reg;
    logic                  free_found_reg;
    logic [OW-1:0]         free_slot_reg;

    kvtio_res_t            res_reg, res_next;

    logic                  key_hit, val_better, ord_hit, take;
    logic [XW-1:0]         ord_ext, idx_ext, hit_ord_ext;
    logic                  ins_ok, rem_ok, renum_we, ord_we;
    logic [OW-1:0]         ord_waddr, ord_wdata;
    logic [CW+COUNT_W-1:0] cnt_ext;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg  <= request.operation;
            key_reg <= request.key_in[TOKEN_BITS-1:0];
            val_reg <= request.value_in[TOKEN_BITS-1:0];
            idx_reg <= request.index_in;
        end
    end

    // Read address counter and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg    <= '0;
            live_reg       <= 1'b0;
            renum_live_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load || ctl.commit)
            begin
                rd_addr_reg <= '0;
            end
            else if (ctl.issue)
            begin
                rd_addr_reg <= rd_addr_reg + OW'(1);
            end
            live_reg       <= ctl.issue;
            renum_live_reg <= ctl.issue && ctl.renum;
        end
    end

    // Registered slot read
    always_ff @(posedge clk)
    begin
        slot_q_reg  <= rd_addr_reg;
        valid_q_reg <= valid_reg[rd_addr_reg];
        key_q_reg   <= key_mem[rd_addr_reg];
        val_q_reg   <= val_mem[rd_addr_reg];
        ord_q_reg   <= ord_mem[rd_addr_reg];
    end

    // Match tests on the slot just read
    assign ord_ext     = XW'(ord_q_reg);
    assign idx_ext     = XW'(idx_reg);
    assign hit_ord_ext = XW'(hit_ord_reg);
    assign key_hit     = valid_q_reg && (key_q_reg == key_reg);
    assign val_better  = valid_q_reg && (val_q_reg == val_reg)
                         && (!found_reg || (key_q_reg < hit_key_reg));
    assign ord_hit     = valid_q_reg && (ord_ext == idx_ext);

    always_comb
    begin
        take = 1'b0;
        if (live_reg && !renum_live_reg)
        begin
            case (op_reg)
                OP_INSERT, OP_REMOVE, OP_FIND_KEY: take = key_hit && !found_reg;
                OP_FIND_VALUE:                     take = val_better;
                OP_FIND_INDEX:                     take = ord_hit && !found_reg;
                default:                           take = 1'b0;
            endcase
        end
    end

    // Scan flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                found_reg <= 1'b1;
            end
            if (live_reg && !renum_live_reg && !valid_q_reg && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    // Matched record and first free slot
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hit_slot_reg <= slot_q_reg;
            hit_key_reg  <= key_q_reg;
            hit_val_reg  <= val_q_reg;
            hit_ord_reg  <= ord_q_reg;
        end
        if (live_reg && !renum_live_reg && !valid_q_reg && !free_found_reg)
        begin
            free_slot_reg <= slot_q_reg;
        end
    end

    // Commit decisions and order write port
    assign ins_ok    = ctl.commit && (op_reg == OP_INSERT) && !found_reg && free_found_reg;
    assign rem_ok    = ctl.commit && (op_reg == OP_REMOVE) && found_reg;
    assign renum_we  = renum_live_reg && valid_q_reg && (ord_q_reg > hit_ord_reg);
    assign ord_we    = ins_ok || renum_we;
    assign ord_waddr = ins_ok ? free_slot_reg : slot_q_reg;
    assign ord_wdata = ins_ok ? count_reg[OW-1:0] : (ord_q_reg - OW'(1));

    always_ff @(posedge clk)
    begin
        if (ins_ok)
        begin
            key_mem[free_slot_reg] <= key_reg;
            val_mem[free_slot_reg] <= val_reg;
        end
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
    end

    // Record count
    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rem_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (ins_ok)
            begin
                valid_reg[free_slot_reg] <= 1'b1;
            end
            else if (rem_ok)
            begin
                valid_reg[hit_slot_reg] <= 1'b0;
            end
            count_reg <= count_next;
        end
    end

    // Result item
    assign cnt_ext = (CW + COUNT_W)'(count_next);

    always_comb
    begin
        res_next           = res_reg;
        res_next.status    = ST_NOT_FOUND;
        res_next.key_out   = '0;
        res_next.value_out = '0;
        res_next.index_out = '0;
        res_next.count_out = cnt_ext[COUNT_W-1:0];
        case (op_reg)
            OP_INSERT:
            begin
                if (found_reg)
                begin
                    res_next.status = ST_DUPLICATE;
                end
                else if (!free_found_reg)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    // new record takes the count before the insert as its index
                    res_next.status    = ST_OK;
                    res_next.key_out   = TOKEN_W'(key_reg);
                    res_next.value_out = TOKEN_W'(val_reg);
                    res_next.index_out = IDX_W'(count_reg);
                end
            end
            OP_REMOVE, OP_FIND_KEY, OP_FIND_VALUE, OP_FIND_INDEX:
            begin
                if (found_reg)
                begin
                    res_next.status    = ST_OK;
                    res_next.key_out   = TOKEN_W'(hit_key_reg);
                    res_next.value_out = TOKEN_W'(hit_val_reg);
                    res_next.index_out = hit_ord_ext[IDX_W-1:0];
                end
            end
            default:
            begin
                res_next.status = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            res_reg <= res_next;
        end
    end

    assign sts.scan_last  = (rd_addr_reg == OW'(ENTRIES - 1));
    assign sts.need_renum = (op_reg == OP_REMOVE) && found_reg;
    assign result         = res_reg;

endmodule

[src/key_value_table_with_insert_order_top.sv]
// Key/value table with insertion order: one operation per start, one result per operation.
// An operation makes one scan pass over all slots; a remove that hits adds a renumbering
// pass. Each pass reads one slot per cycle through the single read port of the record store,
// and a new start is accepted only once the previous operation has finished (busy low).
// done is high for exactly one cycle with the result; the receiver cannot stall it.
// Reset (rst_n low, asynchronous) empties the table: all slots invalid, count zero.
module key_value_table_with_insert_order_top #(
    parameter int ENTRIES    = 16,
    parameter int TOKEN_BITS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  kvtio_pkg::kvtio_req_t request,
    output logic                  done,
    output kvtio_pkg::kvtio_res_t result
);
    import kvtio_pkg::*;

    kvtio_cmd_t ctl;
    kvtio_sts_t sts;

    // Sequencer
    kvtio_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    // Record store and scan logic
    kvtio_datapath #(
        .ENTRIES    (ENTRIES),
        .TOKEN_BITS (TOKEN_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .request (request),
        .sts     (sts),
        .result  (result)
    );

endmodule
